// ----- rtl/ivbus_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the I/O bus controller core.
// No dependencies; imported by the execute core, its checker and the testbench.
package ivbus_pkg;

    localparam int ADDR_W  = 13;
    localparam int DATA_W  = 8;
    localparam int INS_W   = 16;
    localparam int REG_N   = 16;
    localparam int REG_A_W = 4;

    // instruction class in bits 15..13
    typedef enum logic [2:0] {
        OPC_MOVE = 3'd0,
        OPC_ADD  = 3'd1,
        OPC_AND  = 3'd2,
        OPC_XOR  = 3'd3,
        OPC_XEC  = 3'd4,
        OPC_NZT  = 3'd5,
        OPC_XMIT = 3'd6,
        OPC_JMP  = 3'd7
    } t_opc;

    typedef logic [REG_A_W-1:0] t_reg_addr;
    typedef logic [DATA_W-1:0]  t_byte;
    typedef logic [ADDR_W-1:0]  t_addr;

    localparam t_reg_addr REG_AUX = 4'd0;
    localparam t_reg_addr REG_OVF = 4'd8;
    // address registers: low three bits all set
    localparam logic [2:0] REG_ADDR_LOW = 3'b111;
    // XMIT to registers 10/11 is a data write on the bus instead
    localparam logic [2:0] XMIT_BUS_HI = 3'b101;

    // rotate right by n
    function automatic t_byte f_rotr(input t_byte v, input logic [2:0] n);
        logic [2*DATA_W-1:0] w;
        begin
            w = {v, v} >> n;
            return w[DATA_W-1:0];
        end
    endfunction

    // field mask of len bits (0 means 8) shifted to pos, cut to one byte
    function automatic t_byte f_mask(input logic [2:0] len, input logic [2:0] pos);
        t_byte m;
        begin
            if (len == 3'd0) begin
                m = 8'hff;
            end else begin
                m = (8'd1 << len) - 8'd1;
            end
            return m << pos;
        end
    endfunction

endpackage

// ----- rtl/ivbus_controller_instruction_execute.sv -----
`timescale 1ns / 1ps
// Instruction execute core: register-file memory, program counter, result word.
// Depends on ivbus_pkg.

// Executes one 16-bit instruction per input word together with the bus byte
// for the bank it reads, and returns one result word per instruction: next
// fetch address, the bus read/write strobes and the overflow-write flag.
// Throughput is one instruction per clock while the output is not held back.
// An accepted word is held in the execute stage until the output register is
// free or being taken: the accepting edge reads the register file memory
// (sixteen bytes, one read port, one write port, registered read data), and
// the edge that advances the stage executes, writes back and loads the output register.
// A write-back that hits the entry read in the same cycle is forwarded.
// Register 0 is also held in a flip-flop and the overflow register only in one,
// so that ALU operations need no second read port. Reset clears the register file
// through per-entry valid bits at once; there is no clearing pass.
module ivbus_controller_instruction_execute (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [15:0]           i_instruction,
    input  logic [7:0]            i_bus_read_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output ivbus_pkg::t_addr      o_fetch_address,
    output logic                  o_bus_read_used,
    output logic                  o_bus_read_right,
    output logic                  o_bus_write_valid,
    output logic                  o_bus_write_right,
    output logic                  o_bus_write_select,
    output ivbus_pkg::t_byte      o_bus_write_data,
    output logic                  o_overflow_write_error
);
    import ivbus_pkg::*;

    // register file memory
    t_byte            mem [REG_N];
    logic [REG_N-1:0] r_vld;
    t_byte            r_rdata;
    logic             r_rvld;
    logic             r_fwd;
    t_byte            r_fwd_data;
    t_byte            r_reg0;
    logic             r_reg8;

    // execute stage
    logic             r_s1_valid;
    logic [INS_W-1:0] r_s1_ins;
    t_byte            r_s1_rd;
    t_addr            r_pc;

    // output register
    logic  r_o_valid;
    t_addr r_fetch;
    logic  r_rd_used, r_rd_right, r_wr_valid, r_wr_right, r_wr_sel, r_ovf;
    t_byte r_wr_data;

    logic      in_accept;
    logic      s1_adv;
    t_reg_addr raddr;

    // execute results
    t_addr     n_fetch, n_pc;
    logic      n_rd_used, n_rd_right, n_wr_valid, n_wr_right, n_wr_sel, n_ovf;
    t_byte     n_wr_data;
    logic      n_we;
    t_reg_addr n_waddr;
    t_byte     n_wdata;
    logic      n_r8_we, n_r8;
    logic      mem_we;

    assign s1_adv     = r_s1_valid && (!r_o_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_adv;
    assign in_accept  = i_in_valid && o_in_ready;
    assign raddr      = i_instruction[11:8];
    assign mem_we     = s1_adv && n_we;

    always_comb begin
        logic [INS_W-1:0] ins;
        logic [4:0]       s;
        logic [2:0]       l;
        logic [4:0]       d;
        t_byte            reg_s, v, old, bus_v, m, pc_lo;
        logic [8:0]       sum;
        t_addr            pc_inc;
        logic             dst_req, mrg_req, mrg_right;
        t_reg_addr        dst;
        t_byte            dst_val, mrg_v;
        logic [2:0]       mrg_pos;

        ins = r_s1_ins;
        s   = ins[12:8];
        l   = ins[7:5];
        d   = ins[4:0];

        if (s[3:0] == REG_OVF) begin
            reg_s = {7'd0, r_reg8};
        end else if (r_fwd) begin
            reg_s = r_fwd_data;
        end else begin
            reg_s = r_rvld ? r_rdata : 8'd0;
        end

        bus_v  = f_rotr(r_s1_rd, s[2:0]) & f_mask(l, 3'd0);
        pc_inc = r_pc + 13'd1;
        v      = 8'd0;
        old    = 8'd0;
        sum    = 9'd0;
        pc_lo  = 8'd0;
        m      = 8'd0;

        n_pc       = pc_inc;
        n_fetch    = pc_inc;
        n_rd_used  = 1'b0;
        n_rd_right = 1'b0;
        n_wr_valid = 1'b0;
        n_wr_right = 1'b0;
        n_wr_sel   = 1'b0;
        n_wr_data  = 8'd0;
        n_ovf      = 1'b0;
        n_we       = 1'b0;
        n_waddr    = d[3:0];
        n_wdata    = 8'd0;
        n_r8_we    = 1'b0;
        n_r8       = 1'b0;
        dst_req    = 1'b0;
        dst        = d[3:0];
        dst_val    = 8'd0;
        mrg_req    = 1'b0;
        mrg_right  = d[3];
        mrg_v      = 8'd0;
        mrg_pos    = d[2:0];

        case (t_opc'(ins[15:13]))
            OPC_MOVE, OPC_ADD, OPC_AND, OPC_XOR: begin
                if (ins[12]) begin
                    n_rd_used  = 1'b1;
                    n_rd_right = s[3];
                    old        = r_s1_rd;
                    v          = bus_v;
                end else if (ins[4]) begin
                    n_rd_used  = 1'b1;
                    n_rd_right = d[3];
                    old        = r_s1_rd;
                    v          = reg_s;
                end else begin
                    v = f_rotr(reg_s, l);
                end
                case (t_opc'(ins[15:13]))
                    OPC_ADD: begin
                        sum     = {1'b0, v} + {1'b0, r_reg0};
                        n_r8_we = 1'b1;
                        n_r8    = sum[8];
                        v       = sum[7:0];
                    end
                    OPC_AND: v = v & r_reg0;
                    OPC_XOR: v = v ^ r_reg0;
                    default: ;
                endcase
                if (ins[4]) begin
                    mrg_req   = 1'b1;
                    mrg_right = d[3];
                    mrg_v     = v;
                    mrg_pos   = d[2:0];
                end else begin
                    dst_req = 1'b1;
                    dst     = d[3:0];
                    dst_val = v;
                end
            end
            OPC_XEC: begin
                n_pc = r_pc;
                if (!ins[12]) begin
                    pc_lo   = reg_s + ins[7:0];
                    n_fetch = {r_pc[12:8], pc_lo};
                end else begin
                    n_rd_used  = 1'b1;
                    n_rd_right = s[3];
                    pc_lo      = bus_v + {3'd0, ins[4:0]};
                    n_fetch    = {r_pc[12:5], pc_lo[4:0]};
                end
            end
            OPC_NZT: begin
                if (!ins[12]) begin
                    if (reg_s != 8'd0) begin
                        n_pc = {r_pc[12:8], ins[7:0]};
                    end
                end else begin
                    n_rd_used  = 1'b1;
                    n_rd_right = s[3];
                    if (bus_v != 8'd0) begin
                        n_pc = {r_pc[12:5], ins[4:0]};
                    end
                end
                n_fetch = n_pc;
            end
            OPC_XMIT: begin
                if (!ins[12]) begin
                    if (s[3:1] == XMIT_BUS_HI) begin
                        n_wr_valid = 1'b1;
                        n_wr_right = s[0];
                        n_wr_data  = ins[7:0];
                    end else begin
                        dst_req = 1'b1;
                        dst     = s[3:0];
                        dst_val = ins[7:0];
                    end
                end else begin
                    n_rd_used  = 1'b1;
                    n_rd_right = s[3];
                    old        = r_s1_rd;
                    mrg_req    = 1'b1;
                    mrg_right  = s[3];
                    mrg_v      = {3'd0, ins[4:0]};
                    mrg_pos    = s[2:0];
                end
            end
            OPC_JMP: begin
                n_pc    = ins[12:0];
                n_fetch = ins[12:0];
            end
            default: ;
        endcase

        // merge the field into the byte read from the bus
        if (mrg_req) begin
            m          = f_mask(l, mrg_pos);
            n_wr_valid = 1'b1;
            n_wr_right = mrg_right;
            n_wr_sel   = 1'b0;
            n_wr_data  = (old & ~m) | ((mrg_v << mrg_pos) & m);
        end

        // register write; overflow register is read-only
        if (dst_req) begin
            if (dst == REG_OVF) begin
                n_ovf = 1'b1;
            end else begin
                n_we    = 1'b1;
                n_waddr = dst;
                n_wdata = dst_val;
                if (dst[2:0] == REG_ADDR_LOW) begin
                    n_wr_valid = 1'b1;
                    n_wr_right = dst[3];
                    n_wr_sel   = 1'b1;
                    n_wr_data  = dst_val;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
            r_pc       <= '0;
            r_vld      <= '0;
            r_reg0     <= '0;
            r_reg8     <= 1'b0;
            r_rvld     <= 1'b0;
            r_fwd      <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_pc <= n_pc;
                if (n_r8_we) begin
                    r_reg8 <= n_r8;
                end
            end
            if (mem_we) begin
                r_vld[n_waddr] <= 1'b1;
                if (n_waddr == REG_AUX) begin
                    r_reg0 <= n_wdata;
                end
            end
            if (in_accept) begin
                r_rvld <= r_vld[raddr];
                // forward the write-back that lands on the entry being read
                r_fwd  <= mem_we && (n_waddr == raddr);
            end
        end
    end

    // memory and payload
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[n_waddr] <= n_wdata;
        end
        if (in_accept) begin
            r_rdata    <= mem[raddr];
            r_fwd_data <= n_wdata;
            r_s1_ins   <= i_instruction;
            r_s1_rd    <= i_bus_read_data;
        end
        if (s1_adv) begin
            r_fetch    <= n_fetch;
            r_rd_used  <= n_rd_used;
            r_rd_right <= n_rd_right;
            r_wr_valid <= n_wr_valid;
            r_wr_right <= n_wr_right;
            r_wr_sel   <= n_wr_sel;
            r_wr_data  <= n_wr_data;
            r_ovf      <= n_ovf;
        end
    end

    assign o_out_valid            = r_o_valid;
    assign o_fetch_address        = r_fetch;
    assign o_bus_read_used        = r_rd_used;
    assign o_bus_read_right       = r_rd_right;
    assign o_bus_write_valid      = r_wr_valid;
    assign o_bus_write_right      = r_wr_right;
    assign o_bus_write_select     = r_wr_sel;
    assign o_bus_write_data       = r_wr_data;
    assign o_overflow_write_error = r_ovf;

    a_no_ovf_store: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> n_waddr != REG_OVF)
        else $error("write-back to overflow register");

    a_vld_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |=> r_vld[$past(n_waddr)])
        else $error("valid bit not set after write-back");

    a_ovf_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_overflow_write_error) |-> !o_bus_write_valid)
        else $error("bus write on suppressed overflow write");

    a_sel_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_bus_write_select) |-> o_bus_write_valid)
        else $error("select strobe without bus write");

endmodule

// ----- tb/sv/ivbus_exec_checker.sv -----
`timescale 1ns / 1ps
// Result checker for the instruction execute core: predicts each result word
// from the accepted instruction words and compares in order. Depends on ivbus_pkg.
module ivbus_exec_checker (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_ready,
    input  logic [15:0]      i_instruction,
    input  logic [7:0]       i_bus_read_data,
    input  logic             i_out_valid,
    input  logic             i_out_ready,
    input  ivbus_pkg::t_addr i_fetch_address,
    input  logic             i_bus_read_used,
    input  logic             i_bus_read_right,
    input  logic             i_bus_write_valid,
    input  logic             i_bus_write_right,
    input  logic             i_bus_write_select,
    input  ivbus_pkg::t_byte i_bus_write_data,
    input  logic             i_overflow_write_error,
    output int               o_errors,
    output int               o_pending
);
    import ivbus_pkg::*;

    typedef struct packed {
        t_addr fetch;
        logic  rd_used;
        logic  rd_right;
        logic  wr_valid;
        logic  wr_right;
        logic  wr_sel;
        t_byte wr_data;
        logic  ovf_err;
    } t_exec_word;

    // shadow of the core's architectural state
    t_addr pc_q;
    t_addr fetch_q;
    t_byte regs_q [REG_N];

    t_exec_word pending_words [$];
    t_exec_word want;

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic t_byte rotr8(input t_byte v, input logic [2:0] n);
        if (n == 3'd0) begin
            return v;
        end
        return (v >> n) | (v << (4'd8 - {1'b0, n}));
    endfunction

    function automatic t_byte fmask(input logic [2:0] len, input logic [2:0] pos);
        logic [15:0] m;
        m = (len == 3'd0) ? 16'h00ff : ((16'd1 << len) - 16'd1);
        m = m << pos;
        return m[7:0];
    endfunction

    function automatic void merge_out(inout t_exec_word r, input logic right,
                                      input t_byte old, input t_byte v,
                                      input logic [2:0] len, input logic [2:0] pos);
        t_byte       m;
        logic [15:0] w;
        m = fmask(len, pos);
        w = {8'h00, v} << pos;
        r.wr_valid = 1'b1;
        r.wr_right = right;
        r.wr_sel   = 1'b0;
        r.wr_data  = (old & ~m) | (w[7:0] & m);
    endfunction

    function automatic void put_reg(inout t_exec_word r, input t_reg_addr a, input t_byte v);
        if (a == REG_OVF) begin
            r.ovf_err = 1'b1;
            return;
        end
        regs_q[a] = v;
        // address registers also drive a select write on their bank
        if (a[2:0] == REG_ADDR_LOW) begin
            r.wr_valid = 1'b1;
            r.wr_right = a[3];
            r.wr_sel   = 1'b1;
            r.wr_data  = v;
        end
    endfunction

    function automatic t_exec_word run_instruction(input logic [15:0] ins, input t_byte bd);
        t_exec_word r;
        logic [4:0] s;
        logic [4:0] d;
        logic [2:0] l;
        logic [2:0] rot;
        t_byte      v;
        t_byte      old;
        logic [8:0] sum;
        t_opc       opc;
        r   = '0;
        s   = ins[12:8];
        l   = ins[7:5];
        d   = ins[4:0];
        opc = t_opc'(ins[15:13]);
        old = '0;
        rot = '0;
        if (!ins[15]) begin
            if (ins[12]) begin
                r.rd_used  = 1'b1;
                r.rd_right = s[3];
                old = bd;
                v   = bd;
                rot = s[2:0];
            end else begin
                if (d[4]) begin
                    r.rd_used  = 1'b1;
                    r.rd_right = d[3];
                    old = bd;
                end else begin
                    rot = l;
                end
                v = regs_q[s[3:0]];
            end
            v = rotr8(v, rot);
            if (ins[12]) begin
                v = v & fmask(l, 3'd0);
            end
            case (opc)
                OPC_ADD: begin
                    sum = {1'b0, v} + {1'b0, regs_q[REG_AUX]};
                    regs_q[REG_OVF] = {7'd0, sum[8]};
                    v = sum[7:0];
                end
                OPC_AND: v = v & regs_q[REG_AUX];
                OPC_XOR: v = v ^ regs_q[REG_AUX];
                default: ;
            endcase
            if (d[4]) begin
                merge_out(r, d[3], old, v, l, d[2:0]);
            end else begin
                put_reg(r, d[3:0], v);
            end
            pc_q    = pc_q + 13'd1;
            fetch_q = pc_q;
        end else begin
            case (opc)
                OPC_XEC: begin
                    if (ins[12]) begin
                        r.rd_used  = 1'b1;
                        r.rd_right = s[3];
                        v = rotr8(bd, s[2:0]) & fmask(l, 3'd0);
                        fetch_q = {pc_q[12:5], 5'(v[4:0] + ins[4:0])};
                    end else begin
                        fetch_q = {pc_q[12:8], 8'(regs_q[s[3:0]] + ins[7:0])};
                    end
                end
                OPC_NZT: begin
                    if (ins[12]) begin
                        r.rd_used  = 1'b1;
                        r.rd_right = s[3];
                        v = rotr8(bd, s[2:0]) & fmask(l, 3'd0);
                        pc_q = (v != 8'd0) ? {pc_q[12:5], ins[4:0]} : pc_q + 13'd1;
                    end else begin
                        v = regs_q[s[3:0]];
                        pc_q = (v != 8'd0) ? {pc_q[12:8], ins[7:0]} : pc_q + 13'd1;
                    end
                    fetch_q = pc_q;
                end
                OPC_XMIT: begin
                    if (ins[12]) begin
                        r.rd_used  = 1'b1;
                        r.rd_right = s[3];
                        merge_out(r, s[3], bd, {3'd0, ins[4:0]}, l, s[2:0]);
                    end else if (s[3:1] == XMIT_BUS_HI) begin
                        // literal goes straight out as a data write
                        r.wr_valid = 1'b1;
                        r.wr_right = s[0];
                        r.wr_sel   = 1'b0;
                        r.wr_data  = ins[7:0];
                    end else begin
                        put_reg(r, s[3:0], ins[7:0]);
                    end
                    pc_q    = pc_q + 13'd1;
                    fetch_q = pc_q;
                end
                default: begin
                    pc_q    = ins[12:0];
                    fetch_q = pc_q;
                end
            endcase
        end
        r.fetch = fetch_q;
        return r;
    endfunction

    function automatic void check_field(input string what, input int unsigned exp_v,
                                        input int unsigned got_v);
        if (exp_v != got_v) begin
            o_errors++;
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pc_q    = '0;
            fetch_q = '0;
            foreach (regs_q[k]) begin
                regs_q[k] = '0;
            end
            pending_words.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_words.size() == 0) begin
                    o_errors++;
                    $display("%0t: result word with nothing expected, fetch 0x%0h",
                             $time, i_fetch_address);
                end else begin
                    want = pending_words.pop_front();
                    check_field("fetch_address", want.fetch, i_fetch_address);
                    check_field("bus_read_used", want.rd_used, i_bus_read_used);
                    check_field("bus_read_right", want.rd_right, i_bus_read_right);
                    check_field("bus_write_valid", want.wr_valid, i_bus_write_valid);
                    check_field("bus_write_right", want.wr_right, i_bus_write_right);
                    check_field("bus_write_select", want.wr_sel, i_bus_write_select);
                    check_field("bus_write_data", want.wr_data, i_bus_write_data);
                    check_field("overflow_write_error", want.ovf_err, i_overflow_write_error);
                end
            end
            if (i_in_valid && i_in_ready) begin
                pending_words.push_back(run_instruction(i_instruction, i_bus_read_data));
            end
        end
        o_pending = pending_words.size();
    end

endmodule

// ----- tb/sv/tb_ivbus_controller_instruction_execute.sv -----
`timescale 1ns / 1ps
// Testbench top for the execute core: clock, reset, instruction stimulus and
// output back-pressure. Depends on ivbus_pkg, the execute core and ivbus_exec_checker.
module tb_ivbus_controller_instruction_execute;
    import ivbus_pkg::*;

    localparam int RANDOM_WORDS = 1800;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int SQUEEZE_AT   = 600;
    localparam int SQUEEZE_LEN  = 300;

    localparam logic [4:0] R_ADDR_L = 5'd7;
    localparam logic [4:0] R_ADDR_R = 5'd15;
    localparam logic [4:0] R_XMIT_L = 5'd10;
    localparam logic [4:0] R_XMIT_R = 5'd11;
    localparam logic [4:0] R_OVF    = {1'b0, REG_OVF};
    localparam logic [4:0] R_AUX    = {1'b0, REG_AUX};

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_instruction;
    logic [7:0]  i_bus_read_data;
    logic        o_out_valid;
    logic        i_out_ready;
    t_addr       o_fetch_address;
    logic        o_bus_read_used;
    logic        o_bus_read_right;
    logic        o_bus_write_valid;
    logic        o_bus_write_right;
    logic        o_bus_write_select;
    t_byte       o_bus_write_data;
    logic        o_overflow_write_error;

    int   errors;
    int   pending;
    int   cycles;
    int   words_sent;
    logic quiet_tx;

    ivbus_controller_instruction_execute DUT (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_ready             (o_in_ready),
        .i_instruction          (i_instruction),
        .i_bus_read_data        (i_bus_read_data),
        .o_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .o_fetch_address        (o_fetch_address),
        .o_bus_read_used        (o_bus_read_used),
        .o_bus_read_right       (o_bus_read_right),
        .o_bus_write_valid      (o_bus_write_valid),
        .o_bus_write_right      (o_bus_write_right),
        .o_bus_write_select     (o_bus_write_select),
        .o_bus_write_data       (o_bus_write_data),
        .o_overflow_write_error (o_overflow_write_error)
    );

    ivbus_exec_checker u_exec_check (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .i_in_ready             (o_in_ready),
        .i_instruction          (i_instruction),
        .i_bus_read_data        (i_bus_read_data),
        .i_out_valid            (o_out_valid),
        .i_out_ready            (i_out_ready),
        .i_fetch_address        (o_fetch_address),
        .i_bus_read_used        (o_bus_read_used),
        .i_bus_read_right       (o_bus_read_right),
        .i_bus_write_valid      (o_bus_write_valid),
        .i_bus_write_right      (o_bus_write_right),
        .i_bus_write_select     (o_bus_write_select),
        .i_bus_write_data       (o_bus_write_data),
        .i_overflow_write_error (o_overflow_write_error),
        .o_errors               (errors),
        .o_pending              (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("tb: failure");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 65) begin
            return 0;
        end
        if (p < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [15:0] insn(input t_opc op, input logic [4:0] s,
                                         input logic [7:0] low);
        return {op, s, low};
    endfunction

    // call at a falling edge; returns at the falling edge after the word is taken
    task automatic send_word(input logic [15:0] ins, input logic [7:0] bd);
        int n;
        n = quiet_tx ? 0 : pick_gap();
        if (n > 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_instruction   <= ins;
        i_bus_read_data <= bd;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // output back-pressure, with one long hold to fill the pipe
    initial begin
        int   hold;
        int   ticks;
        logic quiet_rx;
        logic squeezed;
        i_out_ready = 1'b0;
        hold     = 0;
        ticks    = 0;
        quiet_rx = 1'b0;
        squeezed = 1'b0;
        forever begin
            @(negedge i_clk);
            ticks++;
            if (ticks % 256 == 0) begin
                quiet_rx = ($urandom_range(0, 3) == 0);
            end
            if (hold > 0) begin
                i_out_ready <= 1'b0;
                hold--;
            end else if (!squeezed && words_sent >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                hold = SQUEEZE_LEN - 1;
                i_out_ready <= 1'b0;
            end else if (quiet_rx) begin
                i_out_ready <= 1'b1;
            end else begin
                hold = pick_gap();
                i_out_ready <= (hold == 0);
                if (hold > 0) begin
                    hold--;
                end
            end
        end
    end

    initial begin
        int          k;
        int          sel;
        logic [15:0] ins;
        logic [7:0]  bd;
        logic [4:0]  hot;
        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_instruction   = '0;
        i_bus_read_data = '0;
        words_sent      = 0;
        quiet_tx        = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_word(16'h0000, 8'h00);
        send_word(insn(OPC_XMIT, R_AUX, 8'hff), 8'h00);
        send_word(insn(OPC_XMIT, 5'd1, 8'h81), 8'hff);
        // carry out of the add lands in the overflow register
        send_word(insn(OPC_ADD, 5'd1, {3'd3, 5'd2}), 8'h00);
        send_word(insn(OPC_MOVE, 5'd2, {3'd0, R_OVF}), 8'h00);
        send_word(insn(OPC_ADD, 5'd1, {3'd0, R_OVF}), 8'h00);
        send_word(insn(OPC_AND, 5'd1, {3'd2, 5'd3}), 8'h00);
        send_word(insn(OPC_XOR, 5'd1, {3'd5, 5'd4}), 8'h00);
        send_word(insn(OPC_XMIT, R_OVF, 8'h5a), 8'h00);
        send_word(insn(OPC_MOVE, 5'd1, {3'd1, R_ADDR_L}), 8'h00);
        send_word(insn(OPC_XMIT, R_ADDR_R, 8'hc3), 8'h00);
        send_word(insn(OPC_XMIT, R_XMIT_L, 8'h00), 8'h00);
        send_word(insn(OPC_XMIT, R_XMIT_R, 8'hff), 8'h00);
        send_word(insn(OPC_MOVE, {2'b11, 3'd7}, {3'd0, 5'd5}), 8'ha5);
        // field runs past bit 7
        send_word(insn(OPC_MOVE, 5'd1, {3'd4, 5'b10111}), 8'h3c);
        send_word(insn(OPC_XOR, {2'b10, 3'd2}, {3'd3, 5'b11010}), 8'hf0);
        send_word(insn(OPC_XMIT, {2'b11, 3'd6}, {3'd0, 5'h1f}), 8'h12);
        send_word(insn(OPC_XEC, R_AUX, 8'h02), 8'h00);
        send_word(insn(OPC_XEC, {2'b10, 3'd1}, {3'd5, 5'h1f}), 8'hff);
        send_word(insn(OPC_NZT, 5'd1, 8'h40), 8'h00);
        send_word(insn(OPC_NZT, 5'd6, 8'h40), 8'h00);
        send_word(insn(OPC_NZT, {2'b11, 3'd0}, {3'd1, 5'h0a}), 8'h01);
        send_word(insn(OPC_NZT, {2'b11, 3'd0}, {3'd1, 5'h0a}), 8'hfe);
        // jump to the top of program space, then step across the wrap
        send_word(16'hffff, 8'hff);
        send_word(insn(OPC_MOVE, R_AUX, {3'd0, 5'd9}), 8'h00);

        for (k = 0; k < RANDOM_WORDS; k++) begin
            if (k % 150 == 0) begin
                quiet_tx = ($urandom_range(0, 3) == 0);
            end
            ins = 16'($urandom);
            sel = $urandom_range(0, 99);
            // steer a good share at the registers with side effects
            if (sel < 35) begin
                case ($urandom_range(0, 5))
                    0:       hot = R_ADDR_L;
                    1:       hot = R_ADDR_R;
                    2:       hot = R_OVF;
                    3:       hot = R_XMIT_L;
                    4:       hot = R_XMIT_R;
                    default: hot = R_AUX;
                endcase
                if (ins[15]) begin
                    ins[12:8] = hot;
                end else begin
                    ins[4:0] = hot;
                end
            end
            sel = $urandom_range(0, 99);
            bd = (sel < 10) ? 8'h00 : (sel < 20) ? 8'hff : 8'($urandom);
            send_word(ins, bd);
        end
        i_in_valid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- ivbus_controller_instruction_execute.f -----
rtl/ivbus_pkg.sv
rtl/ivbus_controller_instruction_execute.sv
tb/sv/ivbus_exec_checker.sv
tb/sv/tb_ivbus_controller_instruction_execute.sv
